/* rtl/core/pisc_pkg.sv */
// ----------------------------------------------------------------------------
// pisc_pkg
// Shared types, constants and helpers for the PI speed controller.
// ----------------------------------------------------------------------------
package pisc_pkg;

	// Q format fractional bits
	localparam int FRAC = 16;

	// register indexes on the config channel
	localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
	localparam logic [2:0] REG_INV_INT    = 3'd1;
	localparam logic [2:0] REG_FILT_BW    = 3'd2;
	localparam logic [2:0] REG_VOLT_LIMIT = 3'd3;
	localparam logic [2:0] REG_TIMEOUT    = 3'd4;

	// register reset values
	localparam logic [31:0] PROP_GAIN_RST  = 32'd7373;
	localparam logic [31:0] INV_INT_RST    = 32'd7000;
	localparam logic [31:0] FILT_BW_RST    = 32'(1 << FRAC);
	localparam logic [31:0] VOLT_LIMIT_RST = 32'(5 << FRAC);
	localparam logic [15:0] TIMEOUT_RST    = 16'd1000;

	localparam logic [32:0] TWO_Q      = 33'(2 << FRAC);
	localparam logic [32:0] CODE_SCALE = 33'd51;

	// (period_ms * T_RECIP) >> T_SHIFT is exactly floor(period_ms * 2^FRAC / 1000)
	// for every 16-bit period; rounding error stays far below the 8/1000 margin
	localparam logic [32:0] T_RECIP = 33'd2199023256;
	localparam int          T_SHIFT = 25;

	// divider iteration count
	localparam logic [5:0] DIV_ITERS_FRAC   = 6'(FRAC);

	typedef struct packed {
		logic        start;
		logic [32:0] rem0;
		logic [31:0] dvd;
		logic [5:0]  iters;
		logic [32:0] den;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic [31:0] quo;
	} div_rsp_t;

	// saturate a wide two's complement value to signed 32 bits
	function automatic logic [31:0] sat32(input logic [67:0] x);
		logic all_one;
		logic all_zero;
		all_one  = &x[67:31];
		all_zero = ~|x[67:31];
		if (all_one || all_zero) begin
			return x[31:0];
		end else if (x[67]) begin
			return 32'h8000_0000;
		end else begin
			return 32'h7fff_ffff;
		end
	endfunction

	function automatic logic [67:0] sx68(input logic [31:0] x);
		return {{36{x[31]}}, x};
	endfunction

endpackage

/* rtl/core/pi_speed_controller_antiwindup_unit.sv */
// ----------------------------------------------------------------------------
// pi_speed_controller_antiwindup_unit
// PI speed controller with reference prefilter and back-calculation anti-windup.
// ----------------------------------------------------------------------------
// One request on the input stream runs one control step and yields one result.
// A step whose message ages pass timeout goes straight to the done state; a
// normal step's time is set mostly by the restoring divider (one run each
// for the two prefilter coefficients) and the single shared multiplier that
// handles eight products in turn, the period scaling being a reciprocal
// multiply. The input is not ready while a step runs. The result sits in an
// output register until taken; a stalled result holds the sequencer in its
// last state.
// Config writes are always accepted and must only be issued while idle.
// Gains, limits and internal values are Q16.16; state saturates to signed 32 bits.
// ----------------------------------------------------------------------------
module pi_speed_controller_antiwindup_unit (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// [15:0] rpm_ref, [31:16] rpm_meas, [47:32] period_ms,
	// [63:48] ref_age_ms, [79:64] meas_age_ms
	input  logic [79:0] s_tdata,
	// [0] brake
	input  logic        s_tuser,
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] drive_code, [39:8] volt_out
	output logic [39:0] m_tdata,
	// [0] timed_out
	output logic        m_tuser,
	// config write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import pisc_pkg::*;

	// sequencer codes
	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_MULT = 5'd1;  // period to Q seconds
	localparam logic [4:0] ST_MULA = 5'd2;  // w*T
	localparam logic [4:0] ST_AW   = 5'd3;
	localparam logic [4:0] ST_DIVG = 5'd4;
	localparam logic [4:0] ST_DIVH = 5'd5;
	localparam logic [4:0] ST_M1   = 5'd6;  // h*filt_prev
	localparam logic [4:0] ST_M2   = 5'd7;  // (ref+ref_prev)*g
	localparam logic [4:0] ST_W2   = 5'd8;
	localparam logic [4:0] ST_M3   = 5'd9;  // e*kp
	localparam logic [4:0] ST_W3   = 5'd10;
	localparam logic [4:0] ST_M4   = 5'd11; // d*ki
	localparam logic [4:0] ST_W4   = 5'd12;
	localparam logic [4:0] ST_M5   = 5'd13; // isum*T
	localparam logic [4:0] ST_W5   = 5'd14;
	localparam logic [4:0] ST_M6   = 5'd15; // v*51
	localparam logic [4:0] ST_W6   = 5'd16;
	localparam logic [4:0] ST_DONE = 5'd17;

	// h is exactly one when a is zero; the divider cannot return that quotient
	localparam logic [17:0] H_UNITY = 18'h1_0000;

	logic [4:0] state_q;

	// config registers
	logic [31:0] kp_q, ki_q, bw_q, vlim_q;
	logic [15:0] tmo_ms_q;

	// controller state
	logic [15:0] ref_prev_q;
	logic [31:0] fprev_q, iprev_q, irp_q, we_q;

	// latched request
	logic [15:0] ref_q, meas_q, per_q;
	logic        brake_q, tmo_q;

	// step temporaries
	logic [31:0] t_q, a_q;
	logic [32:0] den_q;
	logic [15:0] g_q;
	logic [17:0] h_q;
	logic [49:0] acc_q;
	logic [31:0] filt_q, e_q, up_q, d_q, rate_q, isum_q, v_q;
	logic [7:0]  code_q;

	// result register
	logic        out_valid_q;
	logic [7:0]  out_code_q;
	logic [31:0] out_volt_q;
	logic        out_tmo_q;

	div_req_t div_req;
	div_rsp_t div_rsp;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod;

	pisc_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	pisc_mul u_mul (
		.clk  (clk),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (prod)
	);

	logic accept, timeout_hit;
	assign s_tready    = (state_q == ST_IDLE);
	assign accept      = s_tvalid && s_tready;
	assign timeout_hit = (s_tdata[63:48] > tmo_ms_q) || (s_tdata[79:64] > tmo_ms_q);
	assign cfg_ready   = 1'b1;

	// ---- datapath after the shared multiplier ----
	logic signed [65:0] p_sh1, p_sh2;
	assign p_sh1 = prod >>> FRAC;       // floor shift
	assign p_sh2 = prod >>> (FRAC + 1); // floor shift, half of trapezoid

	// step period T in Q seconds, from the reciprocal product
	logic [31:0] t_n;
	assign t_n = prod[T_SHIFT+31:T_SHIFT];

	// prefilter coefficient a, saturated
	logic [31:0] a_n;
	assign a_n = (|prod[65:FRAC+32]) ? 32'hffff_ffff : prod[FRAC+31:FRAC];

	// |2 - a| for the h coefficient
	logic        hneg;
	logic [32:0] hmag;
	assign hneg = ({1'b0, a_q} > TWO_Q);
	assign hmag = hneg ? ({1'b0, a_q} - TWO_Q) : (TWO_Q - {1'b0, a_q});

	logic [31:0] filt_n, e_n, up_n, d_n, rate_n, isum_n, integ_n, v_n, we_n;
	logic [33:0] upi;
	logic [49:0] code_full;

	assign filt_n  = sat32({{18{acc_q[49]}}, acc_q} + {2'b00, prod});
	assign e_n     = sat32(sx68(filt_n) - {36'b0, meas_q, 16'b0});
	assign up_n    = sat32({{2{p_sh1[65]}}, p_sh1});
	assign d_n     = sat32(sx68(up_n) - sx68(we_q));
	assign rate_n  = sat32({{2{p_sh1[65]}}, p_sh1});
	assign isum_n  = sat32(sx68(rate_n) + sx68(irp_q));
	assign integ_n = sat32(sx68(iprev_q) + {{2{p_sh2[65]}}, p_sh2});
	assign upi     = {{2{up_q[31]}}, up_q} + {{2{integ_n[31]}}, integ_n};

	// clamp to 0..volt_limit
	always_comb begin
		if (upi[33]) begin
			v_n = '0;
		end else if (upi[32:0] > {1'b0, vlim_q}) begin
			v_n = vlim_q;
		end else begin
			v_n = upi[31:0];
		end
	end

	// excess fed back to the integrator input
	assign we_n      = sat32({{34{upi[33]}}, upi} - {36'b0, v_n});
	assign code_full = prod[65:FRAC];

	// ---- shared multiplier operand select ----
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MULT: begin
				mul_a = {17'b0, per_q};
				mul_b = T_RECIP;
			end
			ST_MULA: begin
				mul_a = {1'b0, bw_q};
				mul_b = {1'b0, t_n};
			end
			ST_M1: begin
				mul_a = {{15{h_q[17]}}, h_q};
				mul_b = {fprev_q[31], fprev_q};
			end
			ST_M2: begin
				mul_a = 33'({1'b0, ref_q} + {1'b0, ref_prev_q});
				mul_b = {17'b0, g_q};
			end
			ST_M3: begin
				mul_a = {e_q[31], e_q};
				mul_b = {1'b0, kp_q};
			end
			ST_M4: begin
				mul_a = {d_q[31], d_q};
				mul_b = {1'b0, ki_q};
			end
			ST_M5: begin
				mul_a = {isum_q[31], isum_q};
				mul_b = {1'b0, t_q};
			end
			ST_M6: begin
				mul_a = {1'b0, v_q};
				mul_b = CODE_SCALE;
			end
			default: begin
			end
		endcase
	end

	// ---- divider requests ----
	always_comb begin
		div_req = '0;
		case (state_q)
			ST_AW: begin
				// g = a / (a + 2)
				div_req.start = 1'b1;
				div_req.rem0  = {1'b0, a_n};
				div_req.iters = DIV_ITERS_FRAC;
				div_req.den   = {1'b0, a_n} + TWO_Q;
			end
			ST_DIVG: begin
				// |h| = |2 - a| / (a + 2)
				if (!div_rsp.busy) begin
					div_req.start = 1'b1;
					div_req.rem0  = hmag;
					div_req.iters = DIV_ITERS_FRAC;
					div_req.den   = den_q;
				end
			end
			default: begin
			end
		endcase
	end

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ref_prev_q <= '0;
			fprev_q    <= '0;
			iprev_q    <= '0;
			irp_q      <= '0;
			we_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= timeout_hit ? ST_DONE : ST_MULT;
					end
				end
				ST_MULT: state_q <= ST_MULA;
				ST_MULA: state_q <= ST_AW;
				ST_AW:   state_q <= ST_DIVG;
				ST_DIVG: begin
					if (!div_rsp.busy) begin
						state_q <= ST_DIVH;
					end
				end
				ST_DIVH: begin
					if (!div_rsp.busy) begin
						state_q <= ST_M1;
					end
				end
				ST_M1: state_q <= ST_M2;
				ST_M2: state_q <= ST_W2;
				ST_W2: state_q <= ST_M3;
				ST_M3: state_q <= ST_W3;
				ST_W3: state_q <= ST_M4;
				ST_M4: state_q <= ST_W4;
				ST_W4: state_q <= ST_M5;
				ST_M5: state_q <= ST_W5;
				ST_W5: begin
					// commit controller state; brake clears the integrator part
					ref_prev_q <= ref_q;
					fprev_q    <= filt_q;
					iprev_q    <= brake_q ? '0 : integ_n;
					irp_q      <= brake_q ? '0 : rate_q;
					we_q       <= brake_q ? '0 : we_n;
					state_q    <= ST_M6;
				end
				ST_M6: state_q <= ST_W6;
				ST_W6: state_q <= ST_DONE;
				ST_DONE: begin
					if (!out_valid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// step temporaries, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ref_q   <= s_tdata[15:0];
					meas_q  <= s_tdata[31:16];
					per_q   <= s_tdata[47:32];
					brake_q <= s_tuser;
					tmo_q   <= timeout_hit;
				end
			end
			ST_MULA: t_q <= t_n;
			ST_AW: begin
				a_q   <= a_n;
				den_q <= {1'b0, a_n} + TWO_Q;
			end
			ST_DIVG: g_q <= div_rsp.quo[15:0];
			ST_DIVH: begin
				if (a_q == '0) begin
					h_q <= H_UNITY;
				end else begin
					h_q <= hneg ? (18'd0 - {2'b00, div_rsp.quo[15:0]})
					            : {2'b00, div_rsp.quo[15:0]};
				end
			end
			ST_M2: acc_q <= p_sh1[49:0];
			ST_W2: begin
				filt_q <= filt_n;
				e_q    <= e_n;
			end
			ST_W3: begin
				up_q <= up_n;
				d_q  <= d_n;
			end
			ST_W4: begin
				rate_q <= rate_n;
				isum_q <= isum_n;
			end
			ST_W5: v_q <= v_n;
			ST_W6: code_q <= (|code_full[49:8]) ? 8'hff : code_full[7:0];
			default: begin
			end
		endcase
	end

	// ---- result register ----
	logic out_load;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			// timeout and brake both force zero drive
			out_code_q <= (tmo_q || brake_q) ? '0 : code_q;
			out_volt_q <= (tmo_q || brake_q) ? '0 : v_q;
			out_tmo_q  <= tmo_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_volt_q, out_code_q};
	assign m_tuser  = out_tmo_q;

	// ---- config registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q     <= PROP_GAIN_RST;
			ki_q     <= INV_INT_RST;
			bw_q     <= FILT_BW_RST;
			vlim_q   <= VOLT_LIMIT_RST;
			tmo_ms_q <= TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PROP_GAIN:   kp_q     <= cfg_data;
				REG_INV_INT:     ki_q     <= cfg_data;
				REG_FILT_BW:     bw_q     <= cfg_data;
				REG_VOLT_LIMIT:  vlim_q   <= cfg_data;
				REG_TIMEOUT:     tmo_ms_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// ---- assertions ----
	a_tmo_skips: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && timeout_hit) |=> (state_q == ST_DONE))
		else $error("timeout request did not skip the step");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !div_rsp.busy)
		else $error("divider busy while idle");

	a_volt_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[39:8] <= vlim_q))
		else $error("output voltage above limit");

	a_tmo_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0))
		else $error("drive not zero on timeout");

endmodule

/* rtl/core/pisc_divider.sv */
// ----------------------------------------------------------------------------
// pisc_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pisc_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  pisc_pkg::div_req_t req,
	output pisc_pkg::div_rsp_t rsp
);
	import pisc_pkg::*;

	logic [32:0] rem_q;
	logic [32:0] den_q;
	logic [31:0] quo_q;
	logic [5:0]  cnt_q;
	logic [33:0] sh;
	logic [33:0] diff;
	logic        take;

	assign sh   = {rem_q, quo_q[31]};
	assign diff = sh - {1'b0, den_q};
	assign take = (sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= req.iters;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem0;
			den_q <= req.den;
			quo_q <= req.dvd;
		end else if (cnt_q != '0) begin
			rem_q <= take ? diff[32:0] : sh[32:0];
			quo_q <= {quo_q[30:0], take};
		end
	end

	assign rsp.busy = (cnt_q != '0);
	assign rsp.quo  = quo_q;

endmodule

/* rtl/core/pisc_mul.sv */
// ----------------------------------------------------------------------------
// pisc_mul
// Shared signed 33x33 multiplier with registered product.
// ----------------------------------------------------------------------------
module pisc_mul (
	input  logic               clk,
	input  logic signed [32:0] op_a,
	input  logic signed [32:0] op_b,
	output logic signed [65:0] prod
);
	import pisc_pkg::*;

	always_ff @(posedge clk) begin
		prod <= op_a * op_b;
	end

endmodule
